>>> rtl/tlr_pkg.sv
// Shared types and constants for the timestamp linear resampler.
// Used by tlr_ctrl, tlr_datapath and timestamp_linear_resampler_unit; no dependencies.
`default_nettype none

package tlr_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int VEL_BITS_DEF  = 24;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_AXES      = 3;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_LATER = 2'd1,
        STAT_BEFORE   = 2'd2
    } tlr_status_t;

    // where a reference time falls against the held bracket
    typedef enum logic [2:0] {
        KIND_EMPTY,
        KIND_BEFORE,
        KIND_AFTER,
        KIND_SAME,
        KIND_INTERP
    } tlr_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_FINISH
    } tlr_state_t;

    typedef struct packed {
        logic        capture_ref;
        logic        src_update;
        logic        eval_load;
        logic        div_step;
        logic        div_first;
        logic        mul;
        logic        add;
        logic        out_load;
        tlr_status_t out_code;
    } tlr_cmd_t;

    typedef struct packed {
        tlr_kind_t kind;
        logic      out_free;
    } tlr_stat_t;

endpackage

`default_nettype wire

>>> rtl/tlr_ctrl.sv
// Controller state machine for the timestamp linear resampler.
// Depends on tlr_pkg; drives tlr_datapath through tlr_cmd_t.
`default_nettype none

module tlr_ctrl import tlr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    input  wire logic      s_mode,
    output logic           s_tready,
    input  wire tlr_stat_t stat,
    output tlr_cmd_t       cmd
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    tlr_state_t  state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    tlr_status_t code_reg, code_next;
    logic        started_reg, started_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            code_reg    <= STAT_OK;
            started_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            code_reg    <= code_next;
            started_reg <= started_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        code_next    = code_reg;
        started_next = started_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.out_code = code_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_mode) begin
                        cmd.capture_ref = 1'b1;
                        state_next      = ST_EVAL;
                    end else begin
                        cmd.src_update = 1'b1;
                    end
                end
            end
            ST_EVAL: begin
                cmd.eval_load = 1'b1;
                cnt_next      = '0;
                code_next     = STAT_OK;
                unique case (stat.kind)
                    KIND_EMPTY, KIND_AFTER: begin
                        code_next  = STAT_NO_LATER;
                        state_next = ST_FINISH;
                    end
                    KIND_BEFORE: begin
                        // nothing emitted yet: drop silently
                        code_next  = STAT_BEFORE;
                        state_next = started_reg ? ST_FINISH : ST_IDLE;
                    end
                    KIND_SAME:   state_next = ST_MUL;   // ratio stays zero
                    KIND_INTERP: state_next = ST_DIV;
                    default:     state_next = ST_IDLE;
                endcase
            end
            ST_DIV: begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (cnt_reg == '0);
                if (cnt_reg == CNT_W'(FRAC_BITS)) begin
                    state_next = ST_MUL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.add    = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    started_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("output loaded while a result is still held");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(FRAC_BITS))
        else $error("division step counter out of range");

    a_ref_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_mode) |=> !s_tready)
        else $error("reference transfer did not stall the input");

endmodule

`default_nettype wire

>>> rtl/tlr_datapath.sv
// Datapath of the timestamp linear resampler: bracket state, restoring divider,
// per-axis multiply and add, output register. Depends on tlr_pkg.
`default_nettype none

module tlr_datapath import tlr_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int VEL_BITS  = VEL_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic        [TIME_BITS-1:0] in_time,
    input  wire logic signed [VEL_BITS-1:0]  in_vel [NUM_AXES],
    input  wire tlr_cmd_t                    cmd,
    output tlr_stat_t                        stat,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic             [TIME_BITS-1:0] out_time,
    output logic signed      [VEL_BITS-1:0]  out_vel [NUM_AXES],
    output tlr_status_t                      out_status
);

    localparam int PROD_W = FRAC_BITS + VEL_BITS + 3;

    // bracket state
    logic [1:0]                 count_reg;
    logic [TIME_BITS-1:0]       earlier_time_reg, later_time_reg;
    logic signed [VEL_BITS-1:0] earlier_vel_reg [NUM_AXES];
    logic signed [VEL_BITS-1:0] later_vel_reg [NUM_AXES];

    // work registers
    logic [TIME_BITS-1:0]       t_reg, rem_reg, d_reg;
    logic [FRAC_BITS:0]         q_reg;
    logic signed [VEL_BITS-1:0] ev_reg [NUM_AXES];
    logic signed [VEL_BITS:0]   diff_reg [NUM_AXES];
    logic signed [PROD_W-1:0]   prod_reg [NUM_AXES];
    logic signed [VEL_BITS-1:0] res_reg [NUM_AXES];

    logic                         valid_reg;
    logic [TIME_BITS-1:0]         otime_reg;
    logic signed [VEL_BITS-1:0]   ovel_reg [NUM_AXES];
    tlr_status_t                  ostat_reg;

    logic [TIME_BITS-1:0]       e_t;
    logic signed [VEL_BITS-1:0] e_v [NUM_AXES];
    logic                       sel_earlier;
    logic [TIME_BITS:0]         trial, trial_sub;
    logic                       ge;
    logic signed [PROD_W-1:0]   sum [NUM_AXES];

    always_comb begin
        sel_earlier = (count_reg == 2'd2);
        e_t = sel_earlier ? earlier_time_reg : later_time_reg;
        for (int i = 0; i < NUM_AXES; i++) begin
            e_v[i] = sel_earlier ? earlier_vel_reg[i] : later_vel_reg[i];
        end
    end

    always_comb begin
        if (count_reg == 2'd0) begin
            stat.kind = KIND_EMPTY;
        end else if (t_reg < e_t) begin
            stat.kind = KIND_BEFORE;
        end else if (t_reg > later_time_reg) begin
            stat.kind = KIND_AFTER;
        end else if (later_time_reg == e_t) begin
            stat.kind = KIND_SAME;
        end else begin
            stat.kind = KIND_INTERP;
        end
        stat.out_free = !valid_reg || out_ready;
    end

    // restoring division step; remainder stays below the divisor
    always_comb begin
        trial     = cmd.div_first ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        trial_sub = trial - {1'b0, d_reg};
        ge        = (trial >= {1'b0, d_reg});
    end

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            sum[i] = {{(PROD_W-VEL_BITS){ev_reg[i][VEL_BITS-1]}}, ev_reg[i]}
                   + (prod_reg[i] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg        <= 2'd0;
            earlier_time_reg <= '0;
            later_time_reg   <= '0;
            for (int i = 0; i < NUM_AXES; i++) begin
                earlier_vel_reg[i] <= '0;
                later_vel_reg[i]   <= '0;
            end
        end else if (cmd.src_update) begin
            earlier_time_reg <= later_time_reg;
            later_time_reg   <= in_time;
            for (int i = 0; i < NUM_AXES; i++) begin
                earlier_vel_reg[i] <= later_vel_reg[i];
                later_vel_reg[i]   <= in_vel[i];
            end
            if (count_reg != 2'd2) begin
                count_reg <= count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture_ref) begin
            t_reg <= in_time;
        end
        if (cmd.eval_load) begin
            rem_reg <= t_reg - e_t;
            d_reg   <= later_time_reg - e_t;
            q_reg   <= '0;
            for (int i = 0; i < NUM_AXES; i++) begin
                ev_reg[i]   <= e_v[i];
                diff_reg[i] <= {later_vel_reg[i][VEL_BITS-1], later_vel_reg[i]}
                             - {e_v[i][VEL_BITS-1], e_v[i]};
            end
        end else if (cmd.div_step) begin
            rem_reg <= ge ? trial_sub[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            q_reg   <= {q_reg[FRAC_BITS-1:0], ge};
        end
        if (cmd.mul) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                prod_reg[i] <= $signed({1'b0, q_reg}) * diff_reg[i];
            end
        end
        if (cmd.add) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                res_reg[i] <= sum[i][VEL_BITS-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            otime_reg <= t_reg;
            ostat_reg <= cmd.out_code;
            for (int i = 0; i < NUM_AXES; i++) begin
                ovel_reg[i] <= (cmd.out_code == STAT_OK) ? res_reg[i] : '0;
            end
        end
    end

    assign out_valid  = valid_reg;
    assign out_time   = otime_reg;
    assign out_status = ostat_reg;
    assign out_vel    = ovel_reg;

    a_q_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul |-> (q_reg <= {1'b1, {FRAC_BITS{1'b0}}}))
        else $error("interpolation ratio above one");

    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("sample count past saturation");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> valid_reg)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

>>> rtl/timestamp_linear_resampler_unit.sv
// Top level of the timestamp linear resampler: stream ports, field packing.
// Depends on tlr_pkg, tlr_ctrl and tlr_datapath.
//
// Usage:
//   Slave channel s_*: one transfer per item. s_tuser is the mode bit
//   (0 source velocity sample, 1 reference time). s_tdata carries the
//   time stamp and the three velocity axes.
//   A source transfer shifts the held later sample into the earlier slot and
//   stores the new one as the later sample; it produces no result.
//   A reference transfer produces at most one result on the master channel
//   m_*: the interpolated velocity with status in m_tuser, a status code for
//   a miss, or nothing when it lies before the bracket and no result has
//   gone out since reset.
//   Timing: source transfers are taken back to back, one per cycle, while no
//   reference is in work. A reference that interpolates passes the evaluate
//   step, the restoring divider that retires one quotient bit per cycle, the
//   multiply and the add before it reaches the result register; a miss goes
//   from the evaluate step straight to it. The input is stalled while a
//   reference is in work, so the next transfer waits until the result is
//   loaded, or until a dropped reference has been evaluated.
//   The result sits in an output register; when m_tready is low the next
//   reference waits at its final step; sources flow only until it is taken.
//   Reset (aresetn low, synchronous) clears the held samples to zero, the
//   sample count and the output valid.
`default_nettype none

module timestamp_linear_resampler_unit import tlr_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int VEL_BITS  = VEL_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int DATA_W   = TIME_BITS + NUM_AXES * VEL_BITS,
    localparam int TDATA_W  = ((DATA_W + 7) / 8) * 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // time_stamp, vel_x, vel_y, vel_z (lowest bit up), zero padded
    input  wire logic [TDATA_W-1:0] s_tdata,
    // mode
    input  wire logic               s_tuser,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // out_time, out_vel_x, out_vel_y, out_vel_z (lowest bit up), zero padded
    output logic [TDATA_W-1:0]      m_tdata,
    // status
    output logic [1:0]              m_tuser
);

    tlr_cmd_t   cmd;
    tlr_stat_t  stat;

    logic        [TIME_BITS-1:0] in_time;
    logic signed [VEL_BITS-1:0]  in_vel [NUM_AXES];
    logic        [TIME_BITS-1:0] out_time;
    logic signed [VEL_BITS-1:0]  out_vel [NUM_AXES];
    tlr_status_t                 out_status;

    // unpack input fields
    always_comb begin
        in_time = s_tdata[TIME_BITS-1:0];
        for (int i = 0; i < NUM_AXES; i++) begin
            in_vel[i] = s_tdata[TIME_BITS + i*VEL_BITS +: VEL_BITS];
        end
    end

    tlr_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_mode   (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tlr_datapath #(
        .TIME_BITS (TIME_BITS),
        .VEL_BITS  (VEL_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_time    (in_time),
        .in_vel     (in_vel),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_time   (out_time),
        .out_vel    (out_vel),
        .out_status (out_status)
    );

    // pack result fields, padding bits stay zero
    assign m_tdata = TDATA_W'({out_vel[2], out_vel[1], out_vel[0], out_time});
    assign m_tuser = out_status;

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for timestamp_linear_resampler_unit: directed bracket cases,
// then a long random time-ordered stream with noise. Depends on tlr_pkg and the RTL.

module testbench;
    import tlr_pkg::*;

    localparam int TDATA_W   = ((TIME_BITS_DEF + NUM_AXES * VEL_BITS_DEF + 7) / 8) * 8;
    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int CYCLE_CAP = 500000;
    localparam int DRAIN     = 40;     // well past the time one interpolation takes
    localparam logic MODE_SRC = 1'b0;
    localparam logic MODE_REF = 1'b1;
    localparam logic [23:0] VEL_MAX = 24'h7FFFFF;
    localparam logic [23:0] VEL_MIN = 24'h800000;
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        tlr_status_t      status;
        logic [2:0][23:0] vel;    // [0] is x
        logic [47:0]      ts;
    } resampled_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    // time_stamp, vel_x, vel_y, vel_z (lowest bit up)
    logic [TDATA_W-1:0] s_tdata  = '0;
    // mode
    logic               s_tuser  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // out_time, out_vel_x, out_vel_y, out_vel_z (lowest bit up)
    logic [TDATA_W-1:0] m_tdata;
    // status
    logic [1:0]         m_tuser;

    timestamp_linear_resampler_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    // bracket state of the block as the bench sees it
    int                 held_count = 0;
    logic [47:0]        early_ts   = '0;
    logic [47:0]        late_ts    = '0;
    logic signed [23:0] early_vel [3];
    logic signed [23:0] late_vel [3];
    logic               emitted    = 1'b0;

    resampled_t  resampled_due [$];
    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int          idle_pct       = 20;   // 0 turns idling off on both sides
    int          stall_left     = 0;

    initial begin
        for (int a = 0; a < 3; a++) begin
            early_vel[a] = '0;
            late_vel[a]  = '0;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < 100)
            $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Apply one accepted transfer to the bracket state; queue the result it causes.
    function automatic void interpolate_transfer(logic mode, logic [47:0] ts, logic [71:0] vels);
        resampled_t         res;
        logic [47:0]        base_ts;
        logic signed [23:0] base_vel [3];
        logic [63:0]        num;
        logic [63:0]        den;
        logic [63:0]        ratio;
        longint             span_v;
        longint             val;
        int                 a;
        if (mode == MODE_SRC) begin
            early_ts = late_ts;
            for (a = 0; a < 3; a++) begin
                early_vel[a] = late_vel[a];
                late_vel[a]  = vels[24*a +: 24];
            end
            late_ts = ts;
            if (held_count < 2)
                held_count++;
            return;
        end
        res.ts  = ts;
        res.vel = '0;
        if (held_count == 0) begin
            res.status = STAT_NO_LATER;
            emitted = 1'b1;
            resampled_due = {resampled_due, res};
            return;
        end
        // with one sample the bracket collapses onto it
        for (a = 0; a < 3; a++)
            base_vel[a] = (held_count >= 2) ? early_vel[a] : late_vel[a];
        base_ts = (held_count >= 2) ? early_ts : late_ts;
        if (ts < base_ts) begin
            if (!emitted)
                return;     // dropped while nothing has gone out yet
            res.status = STAT_BEFORE;
            resampled_due = {resampled_due, res};
            return;
        end
        if (ts > late_ts) begin
            res.status = STAT_NO_LATER;
            emitted = 1'b1;
            resampled_due = {resampled_due, res};
            return;
        end
        ratio = '0;
        if (late_ts != base_ts) begin
            num   = 64'(ts - base_ts);
            num   = num << FRAC;
            den   = 64'(late_ts - base_ts);
            ratio = num / den;
        end
        for (a = 0; a < 3; a++) begin
            span_v = longint'(late_vel[a]) - longint'(base_vel[a]);
            val    = longint'(base_vel[a]) + ((longint'(ratio) * span_v) >>> FRAC);
            res.vel[a] = val[23:0];
        end
        res.status = STAT_OK;
        emitted = 1'b1;
        resampled_due = {resampled_due, res};
    endfunction

    function automatic logic [71:0] vel3(logic [23:0] x, logic [23:0] y, logic [23:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [71:0] rand_vels();
        return 72'({$urandom, $urandom, $urandom});
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic mode, input logic [47:0] ts, input logic [71:0] vels);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {vels, ts};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        interpolate_transfer(mode, ts, vels);
        @(negedge aclk);
    endtask

    // Output side: random stall bursts unless idling is off.
    always @(negedge aclk) begin
        if (idle_pct == 0) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 99) < idle_pct / 2) begin
            m_tready   <= 1'b0;
            stall_left = $urandom_range(1, 13) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        resampled_t want;
        int         a;
        if (aresetn && m_tvalid && m_tready) begin
            if (resampled_due.size() == 0) begin
                report_mismatch("result with none pending", 64'(m_tdata[47:0]), 64'd0);
            end else begin
                want = resampled_due.pop_front();
                if (m_tdata[47:0] !== want.ts)
                    report_mismatch("out_time", 64'(m_tdata[47:0]), 64'(want.ts));
                for (a = 0; a < 3; a++)
                    if (m_tdata[48 + 24*a +: 24] !== want.vel[a])
                        report_mismatch($sformatf("velocity axis %0d", a),
                                        64'(m_tdata[48 + 24*a +: 24]), 64'(want.vel[a]));
                if (m_tuser !== want.status)
                    report_mismatch("status", 64'(m_tuser), 64'(want.status));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Either the empty-bracket answer or the early drop, chosen per run,
    // since both exist only before the first result.
    task automatic test_startup();
        if ($urandom_range(0, 1))
            send_item(MODE_REF, 48'd0, rand_vels());
        send_item(MODE_SRC, 48'd5000, vel3(VEL_MAX, VEL_MIN, 24'd0));
        send_item(MODE_REF, 48'd4999, rand_vels());
        send_item(MODE_REF, 48'd0, rand_vels());
        send_item(MODE_REF, 48'd5000, rand_vels());   // single sample held
        send_item(MODE_REF, 48'd5001, rand_vels());
    endtask

    task automatic test_brackets();
        send_item(MODE_SRC, 48'd6000, vel3(VEL_MIN, VEL_MAX, 24'hFFFFFF));
        send_item(MODE_REF, 48'd5000, rand_vels());
        send_item(MODE_REF, 48'd5500, rand_vels());
        send_item(MODE_REF, 48'd5999, rand_vels());
        send_item(MODE_REF, 48'd6000, rand_vels());
        send_item(MODE_REF, 48'd4999, rand_vels());
        send_item(MODE_REF, 48'd7000, rand_vels());
        // zero-width bracket hands back the earlier sample
        send_item(MODE_SRC, 48'd6000, vel3(24'h123456, 24'hABCDEF, VEL_MAX));
        send_item(MODE_REF, 48'd6000, rand_vels());
    endtask

    task automatic test_time_extremes();
        send_item(MODE_SRC, 48'd0, vel3(VEL_MAX, VEL_MAX, VEL_MIN));
        send_item(MODE_SRC, TIME_MAX, vel3(VEL_MIN, VEL_MIN, VEL_MAX));
        send_item(MODE_REF, 48'd1, rand_vels());
        send_item(MODE_REF, 48'h8000_0000_0000, rand_vels());
        send_item(MODE_REF, TIME_MAX - 1, rand_vels());
        send_item(MODE_REF, TIME_MAX, rand_vels());
        send_item(MODE_SRC, TIME_MAX, rand_vels());
        send_item(MODE_REF, TIME_MAX, rand_vels());
    endtask

    // Mostly time-ordered sources with references inside, past and ahead of
    // the bracket; a few jumps and fully random items as noise.
    task automatic test_random_stream(input int count, input int calm_tail);
        logic [47:0] ts;
        logic [47:0] base_ts;
        logic [63:0] span;
        int          pick;
        for (int n = 0; n < count; n++) begin
            if (n >= count - calm_tail)
                idle_pct = 0;
            else if (n % 100 == 0)
                idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 45);
            base_ts = (held_count >= 2) ? early_ts : late_ts;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    ts = late_ts;
                else if (pick < 90)
                    ts = late_ts + $urandom_range(1, 3000);
                else if (pick < 97)
                    ts = late_ts + {$urandom} % 48'h100_0000_0000;
                else
                    ts = 48'({$urandom, $urandom});
                send_item(MODE_SRC, ts, rand_vels());
            end else if (pick < 85) begin
                if (late_ts < base_ts) begin
                    ts = late_ts;
                end else begin
                    span = 64'(late_ts - base_ts);
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        ts = base_ts;
                    else if (pick == 1)
                        ts = late_ts;
                    else
                        ts = base_ts + 48'({$urandom, $urandom} % (span + 1));
                end
                send_item(MODE_REF, ts, rand_vels());
            end else if (pick < 93) begin
                send_item(MODE_REF, late_ts + $urandom_range(1, 500), rand_vels());
            end else if (pick < 97) begin
                send_item(MODE_REF, base_ts - $urandom_range(1, 500), rand_vels());
            end else begin
                send_item(logic'($urandom_range(0, 1)), 48'({$urandom, $urandom}),
                          rand_vels());
            end
        end
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_startup();
        test_brackets();
        test_time_extremes();
        test_random_stream(1830, 150);
        s_tvalid <= 1'b0;
        while (resampled_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (resampled_due.size() != 0)
            report_mismatch("results never arrived", 64'(resampled_due.size()), 64'd0);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/tlr_pkg.sv
rtl/tlr_ctrl.sv
rtl/tlr_datapath.sv
rtl/timestamp_linear_resampler_unit.sv
dv/testbench.sv
